/* design/ipd_pkg.sv */
// Shared types, constants and field layout for the IMU packet deframer.
package ipd_pkg;

  localparam int CNT_W       = 6;
  localparam int FIELD_COUNT = 22;
  localparam int SIGNED_FIRST = 10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Header byte positions
  localparam int POS_SYNC0   = 0;
  localparam int POS_SYNC1   = 1;
  localparam int POS_VERSION = 2;
  localparam int POS_TYPE    = 3;
  localparam int POS_LEN_LO  = 4;
  localparam int POS_LEN_HI  = 5;

  localparam logic [4:0] FIELD_LAST   = 5'(FIELD_COUNT - 1);
  localparam logic [4:0] FIELD_SIGNED = 5'(SIGNED_FIRST);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_BAD_SYNC = 3'd2,
    ST_BAD_CKS  = 3'd3,
    ST_BAD_HDR  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_VERSION     = 2'd2,
    CFG_TYPE        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [7:0]       cks;
  } intake_t;

  // Byte count of each decoded field; fields sit back to back from byte 2
  function automatic logic [2:0] fld_bytes(input logic [4:0] idx);
    logic [2:0] n;
    unique case (idx)
      5'd0, 5'd1, 5'd7, 5'd8: n = 3'd1;
      5'd4:                   n = 3'd4;
      default:                n = 3'd2;
    endcase
    return n;
  endfunction

endpackage

/* design/ipd_byte_store.sv */
// Byte store memory with write-side byte counter and running XOR checksum.
module ipd_byte_store
  import ipd_pkg::*;
#(
  parameter int FRAME_BYTES = 45,
  localparam int AW = $clog2(FRAME_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [7:0]    wr_data,
  input  logic          wr_final,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  output intake_t       intake
);

  logic [7:0]       store_mem [FRAME_BYTES];
  logic [7:0]       rd_data_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       cks_r, cks_nxt;
  logic             in_frame;
  logic             in_cks;

  assign in_frame = cnt_r < CNT_W'(FRAME_BYTES);
  assign in_cks   = (cnt_r >= CNT_W'(POS_VERSION)) && in_frame;

  always_comb begin
    cnt_nxt = cnt_r;
    cks_nxt = cks_r;
    if (wr_en) begin
      if (wr_final) begin
        cnt_nxt = '0;
        cks_nxt = '0;
      end else begin
        if (cnt_r != CNT_MAX) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (in_cks) begin
          cks_nxt = cks_r ^ wr_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cks_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      cks_r <= cks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && in_frame) begin
      store_mem[cnt_r[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign rd_data      = rd_data_r;
  assign intake.count = cnt_r;
  assign intake.cks   = cks_r;

endmodule

/* design/imu_packet_deframer.sv */
// IMU packet deframer top level: frame checks, field decode and result register.
//
// Bytes are taken one per cycle while the block is collecting a buffer and go
// straight into the byte store; the byte count and the XOR checksum are kept on
// the fly. The beat flagged end_of_buffer closes the buffer. A buffer of the
// wrong length goes to the error state, which emits its result. Otherwise the
// header bytes 0 to 5 are read back from the store, each with a read state and
// then a compare state, and the verdict is taken on the compare of byte 5. A
// good packet then streams bytes 2 to 43 out of the store, with a read and an
// assemble state per byte, giving 22 results; the single read port of the
// store sets that pace. Stalls on the result side hold the sequencer. No input
// beat is taken from the final byte until the last result of the buffer sits
// in the output register; the next buffer may start while that result waits.
module imu_packet_deframer
  import ipd_pkg::*;
#(
  parameter int FRAME_BYTES = 45
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_buffer,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status_code,
  output logic [4:0]         out_field_index,
  output logic signed [32:0] out_field_value,
  output logic [31:0]        out_good_count,
  output logic [31:0]        out_error_count,
  output logic [31:0]        out_receive_time_ms,
  output logic               out_last_of_run,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam logic [15:0] LEN_FIELD = 16'(FRAME_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_RD,
    S_CHK_DAT,
    S_ERR,
    S_EMIT_RD,
    S_EMIT_DAT
  } state_t;

  state_t         state_r;
  logic [7:0]     sync_first_r, sync_second_r, version_r, type_r;
  logic [31:0]    now_r;
  logic           cks_ok_r, sync_bad_r, hdr_bad_r;
  status_t        status_r;
  logic [AW-1:0]  rd_addr_r;
  logic [4:0]     fld_r;
  logic [1:0]     pos_r;
  logic [31:0]    asm_r, asm_nxt;
  logic [31:0]    accepted_r, rejected_r, last_time_r;

  logic           out_valid_r;
  status_t        out_status_r;
  logic [4:0]     out_index_r;
  logic [32:0]    out_value_r;
  logic [31:0]    out_good_r, out_err_r, out_time_r;
  logic           out_last_r;

  logic           in_acc;
  logic           out_free;
  logic           out_load;
  logic           rd_en;
  logic [7:0]     rd_data;
  intake_t        intake;
  logic           fld_done;
  logic [32:0]    fld_value;
  logic [7:0]     hdr_expect;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = out_free && ((state_r == S_ERR) || (state_r == S_EMIT_DAT && fld_done));
  assign rd_en    = (state_r == S_CHK_RD) || (state_r == S_EMIT_RD);

  ipd_byte_store #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc),
    .wr_data  (in_data_byte),
    .wr_final (in_end_of_buffer),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr_r),
    .rd_data  (rd_data),
    .intake   (intake)
  );

  // Field assembly
  always_comb begin
    asm_nxt = asm_r;
    asm_nxt[pos_r*8 +: 8] = rd_data;
    fld_done = ({1'b0, pos_r} + 3'd1) == fld_bytes(fld_r);
    if (fld_r >= FIELD_SIGNED) begin
      fld_value = {{17{asm_nxt[15]}}, asm_nxt[15:0]};
    end else begin
      fld_value = {1'b0, asm_nxt};
    end
  end

  always_comb begin
    unique case (rd_addr_r)
      AW'(POS_SYNC0):   hdr_expect = sync_first_r;
      AW'(POS_SYNC1):   hdr_expect = sync_second_r;
      AW'(POS_VERSION): hdr_expect = version_r;
      AW'(POS_TYPE):    hdr_expect = type_r;
      AW'(POS_LEN_LO):  hdr_expect = LEN_FIELD[7:0];
      default:          hdr_expect = LEN_FIELD[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= '0;
      sync_second_r <= '0;
      version_r     <= '0;
      type_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        CFG_VERSION:     version_r     <= cfg_wdata;
        CFG_TYPE:        type_r        <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      accepted_r  <= '0;
      rejected_r  <= '0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_end_of_buffer) begin
            now_r      <= in_now_ms;
            cks_ok_r   <= (intake.cks ^ in_data_byte) == 8'd0;
            sync_bad_r <= 1'b0;
            hdr_bad_r  <= 1'b0;
            rd_addr_r  <= '0;
            if (intake.count == CNT_W'(FRAME_BYTES - 1)) begin
              state_r <= S_CHK_RD;
            end else begin
              status_r <= ST_BAD_LEN;
              if (rejected_r != '1) begin
                rejected_r <= rejected_r + 32'd1;
              end
              state_r <= S_ERR;
            end
          end
        end
        S_CHK_RD: begin
          state_r <= S_CHK_DAT;
        end
        S_CHK_DAT: begin
          if (rd_addr_r == AW'(POS_LEN_HI)) begin
            // Verdict in check order: sync, checksum, header
            if (sync_bad_r || (rd_data != hdr_expect && rd_addr_r <= AW'(POS_SYNC1)) ||
                !cks_ok_r || hdr_bad_r || rd_data != hdr_expect) begin
              if (sync_bad_r) begin
                status_r <= ST_BAD_SYNC;
              end else if (!cks_ok_r) begin
                status_r <= ST_BAD_CKS;
              end else begin
                status_r <= ST_BAD_HDR;
              end
              if (rejected_r != '1) begin
                rejected_r <= rejected_r + 32'd1;
              end
              state_r <= S_ERR;
            end else begin
              if (accepted_r != '1) begin
                accepted_r <= accepted_r + 32'd1;
              end
              last_time_r <= now_r;
              rd_addr_r   <= AW'(POS_VERSION);
              fld_r       <= '0;
              pos_r       <= '0;
              asm_r       <= '0;
              state_r     <= S_EMIT_RD;
            end
          end else begin
            if (rd_data != hdr_expect) begin
              if (rd_addr_r <= AW'(POS_SYNC1)) begin
                sync_bad_r <= 1'b1;
              end else begin
                hdr_bad_r <= 1'b1;
              end
            end
            rd_addr_r <= rd_addr_r + AW'(1);
            state_r   <= S_CHK_RD;
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_status_r <= status_r;
            out_index_r  <= '0;
            out_value_r  <= '0;
            out_good_r   <= accepted_r;
            out_err_r    <= rejected_r;
            out_time_r   <= last_time_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_DAT;
        end
        S_EMIT_DAT: begin
          if (!fld_done) begin
            asm_r     <= asm_nxt;
            pos_r     <= pos_r + 2'd1;
            rd_addr_r <= rd_addr_r + AW'(1);
            state_r   <= S_EMIT_RD;
          end else if (out_free) begin
            out_status_r <= ST_OK;
            out_index_r  <= fld_r;
            out_value_r  <= fld_value;
            out_good_r   <= accepted_r;
            out_err_r    <= rejected_r;
            out_time_r   <= last_time_r;
            out_last_r   <= (fld_r == FIELD_LAST);
            asm_r        <= '0;
            pos_r        <= '0;
            rd_addr_r    <= rd_addr_r + AW'(1);
            fld_r        <= fld_r + 5'd1;
            state_r      <= (fld_r == FIELD_LAST) ? S_IDLE : S_EMIT_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status_code     = out_status_r;
  assign out_field_index     = out_index_r;
  assign out_field_value     = out_value_r;
  assign out_good_count      = out_good_r;
  assign out_error_count     = out_err_r;
  assign out_receive_time_ms = out_time_r;
  assign out_last_of_run     = out_last_r;

endmodule

/* design/ipd_checker.sv */
// Port-level assertions for the IMU packet deframer and their bind.
module ipd_checker
  import ipd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status_code,
  input logic [4:0]         out_field_index,
  input logic signed [32:0] out_field_value,
  input logic               out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_field_value) &&
      $stable(out_field_index) && $stable(out_status_code))
    else $error("result beat changed while stalled");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_code != ST_OK |->
      out_last_of_run && out_field_index == 5'd0 && out_field_value == 33'sd0)
    else $error("error beat malformed");

  a_ok_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_code == ST_OK |->
      (out_last_of_run == (out_field_index == FIELD_LAST)))
    else $error("run end does not match final field");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_field_index <= FIELD_LAST)
    else $error("field index out of range");

endmodule

bind imu_packet_deframer ipd_checker u_ipd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status_code (out_status_code),
  .out_field_index (out_field_index),
  .out_field_value (out_field_value),
  .out_last_of_run (out_last_of_run)
);

/* tb/sv/imu_packet_deframer_tb.sv */
// Self-checking testbench for the IMU packet deframer: byte-level frame predictor and driver.
`timescale 1ns / 100ps

import ipd_pkg::*;

localparam int FRAME_LEN   = 45;
localparam int COUNT_CEIL  = 63;
localparam int FIELDS      = 22;

typedef enum int {
  FK_U8,
  FK_U16,
  FK_U32,
  FK_S16
} field_kind_t;

typedef enum int {
  DEF_NONE,
  DEF_SHORT,
  DEF_LONG,
  DEF_SYNC_FIRST,
  DEF_SYNC_SECOND,
  DEF_CHECKSUM,
  DEF_VERSION,
  DEF_TYPE,
  DEF_LEN_LO,
  DEF_LEN_HI,
  DEF_NOISE
} frame_defect_t;

typedef struct {
  status_t     status;
  logic [4:0]  index;
  logic [32:0] value;
  logic [31:0] good;
  logic [31:0] bad;
  logic [31:0] rx_time;
  logic        last;
} field_beat_t;

class deframe_predictor;
  logic [7:0]  frame_mem [FRAME_LEN];
  int unsigned byte_cnt;
  logic [31:0] good_total;
  logic [31:0] bad_total;
  logic [31:0] last_rx_time;
  logic [7:0]  sync0;
  logic [7:0]  sync1;
  logic [7:0]  version;
  logic [7:0]  ptype;
  field_beat_t expected_q[$];
  int          mismatches;

  function new();
    foreach (frame_mem[i]) frame_mem[i] = 8'h00;
    byte_cnt     = 0;
    good_total   = '0;
    bad_total    = '0;
    last_rx_time = '0;
    sync0        = '0;
    sync1        = '0;
    version      = '0;
    ptype        = '0;
    mismatches   = 0;
  endfunction

  function void set_reg(cfg_reg_t r, logic [7:0] v);
    case (r)
      CFG_SYNC_FIRST:  sync0 = v;
      CFG_SYNC_SECOND: sync1 = v;
      CFG_VERSION:     version = v;
      CFG_TYPE:        ptype = v;
      default: ;
    endcase
  endfunction

  function logic [32:0] decode(int k);
    int          offs [FIELDS] = '{2, 3, 4, 6, 8, 12, 14, 16, 17, 18, 20, 22,
                                   24, 26, 28, 30, 32, 34, 36, 38, 40, 42};
    field_kind_t kinds [FIELDS] = '{FK_U8, FK_U8, FK_U16, FK_U16, FK_U32, FK_U16,
                                    FK_U16, FK_U8, FK_U8, FK_U16, FK_S16, FK_S16,
                                    FK_S16, FK_S16, FK_S16, FK_S16, FK_S16, FK_S16,
                                    FK_S16, FK_S16, FK_S16, FK_S16};
    int          p;
    logic [15:0] lo16;
    p = offs[k];
    lo16 = {frame_mem[p + 1], frame_mem[p]};
    case (kinds[k])
      FK_U8:  return {25'd0, frame_mem[p]};
      FK_U16: return {17'd0, lo16};
      FK_U32: return {1'b0, frame_mem[p + 3], frame_mem[p + 2], lo16};
      default: return {{17{lo16[15]}}, lo16};
    endcase
  endfunction

  function void note_beat(logic [7:0] d, logic eob, logic [31:0] now);
    status_t     verdict;
    logic [7:0]  cks;
    int unsigned len;
    field_beat_t r;
    if (byte_cnt < FRAME_LEN) frame_mem[byte_cnt] = d;
    if (byte_cnt < COUNT_CEIL) byte_cnt++;
    if (!eob) return;
    len = byte_cnt;
    byte_cnt = 0;
    verdict = ST_OK;
    if (len != FRAME_LEN) begin
      verdict = ST_BAD_LEN;
    end else if (frame_mem[0] != sync0 || frame_mem[1] != sync1) begin
      verdict = ST_BAD_SYNC;
    end else begin
      cks = 8'h00;
      for (int i = 2; i < FRAME_LEN - 1; i++) cks ^= frame_mem[i];
      if (cks != frame_mem[FRAME_LEN - 1]) begin
        verdict = ST_BAD_CKS;
      end else if (frame_mem[2] != version || frame_mem[3] != ptype ||
                   {frame_mem[5], frame_mem[4]} != 16'(FRAME_LEN)) begin
        verdict = ST_BAD_HDR;
      end
    end
    if (verdict != ST_OK) begin
      if (bad_total != '1) bad_total++;
      r.status  = verdict;
      r.index   = '0;
      r.value   = '0;
      r.good    = good_total;
      r.bad     = bad_total;
      r.rx_time = last_rx_time;
      r.last    = 1'b1;
      expected_q.push_back(r);
      return;
    end
    if (good_total != '1) good_total++;
    last_rx_time = now;
    for (int k = 0; k < FIELDS; k++) begin
      r.status  = ST_OK;
      r.index   = 5'(k);
      r.value   = decode(k);
      r.good    = good_total;
      r.bad     = bad_total;
      r.rx_time = last_rx_time;
      r.last    = (k == FIELDS - 1);
      expected_q.push_back(r);
    end
  endfunction

  function void diff_field(string name, logic [32:0] want, logic [32:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(field_beat_t got);
    field_beat_t want;
    if (expected_q.size() == 0) begin
      $error("result beat with nothing expected: status %0d index %0d",
             got.status, got.index);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    diff_field("status_code", 33'(want.status), 33'(got.status));
    diff_field("field_index", 33'(want.index), 33'(got.index));
    diff_field("field_value", want.value, got.value);
    diff_field("good_count", 33'(want.good), 33'(got.good));
    diff_field("error_count", 33'(want.bad), 33'(got.bad));
    diff_field("receive_time_ms", 33'(want.rx_time), 33'(got.rx_time));
    diff_field("last_of_run", 33'(want.last), 33'(got.last));
  endfunction
endclass

module imu_packet_deframer_tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte = 8'h00;
  logic               in_end_of_buffer = 1'b0;
  logic [31:0]        in_now_ms = 32'h0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status_code;
  logic [4:0]         out_field_index;
  logic signed [32:0] out_field_value;
  logic [31:0]        out_good_count;
  logic [31:0]        out_error_count;
  logic [31:0]        out_receive_time_ms;
  logic               out_last_of_run;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = 2'd0;
  logic [7:0]         cfg_wdata = 8'h00;

  deframe_predictor sb;
  logic [7:0]       frame_q[$];
  int               beats_sent = 0;
  bit               idle_enable = 1'b1;

  imu_packet_deframer #(.FRAME_BYTES(FRAME_LEN)) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_end_of_buffer    (in_end_of_buffer),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status_code     (out_status_code),
    .out_field_index     (out_field_index),
    .out_field_value     (out_field_value),
    .out_good_count      (out_good_count),
    .out_error_count     (out_error_count),
    .out_receive_time_ms (out_receive_time_ms),
    .out_last_of_run     (out_last_of_run),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin : result_mon
    field_beat_t got;
    if (rst_n && out_valid && out_ready && sb != null) begin
      got.status  = status_t'(out_status_code);
      got.index   = out_field_index;
      got.value   = out_field_value;
      got.good    = out_good_count;
      got.bad     = out_error_count;
      got.rx_time = out_receive_time_ms;
      got.last    = out_last_of_run;
      sb.check_result(got);
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      if (idle_enable && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic cfg_write_all(input logic [7:0] s0, input logic [7:0] s1,
                               input logic [7:0] ver, input logic [7:0] typ);
    cfg_reg_t   regs [4] = '{CFG_SYNC_FIRST, CFG_SYNC_SECOND, CFG_VERSION, CFG_TYPE};
    logic [7:0] vals [4];
    vals = '{s0, s1, ver, typ};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      sb.set_reg(regs[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic build_frame(input frame_defect_t d, input int fill, input int span);
    logic [7:0] mask;
    logic [7:0] cks;
    frame_q.delete();
    for (int i = 0; i < FRAME_LEN; i++)
      frame_q.push_back(fill < 0 ? 8'($urandom) : (i % 2 ? fill[15:8] : fill[7:0]));
    frame_q[0] = sb.sync0;
    frame_q[1] = sb.sync1;
    frame_q[2] = sb.version;
    frame_q[3] = sb.ptype;
    frame_q[4] = 8'(FRAME_LEN);
    frame_q[5] = 8'h00;
    mask = 8'($urandom_range(1, 255));
    case (d)
      DEF_VERSION: frame_q[2] ^= mask;
      DEF_TYPE:    frame_q[3] ^= mask;
      DEF_LEN_LO:  frame_q[4] ^= mask;
      DEF_LEN_HI:  frame_q[5] ^= mask;
      default: ;
    endcase
    cks = 8'h00;
    for (int i = 2; i < FRAME_LEN - 1; i++) cks ^= frame_q[i];
    frame_q[FRAME_LEN - 1] = cks;
    case (d)
      DEF_SYNC_FIRST:  frame_q[0] ^= mask;
      DEF_SYNC_SECOND: frame_q[1] ^= mask;
      DEF_CHECKSUM:    frame_q[FRAME_LEN - 1] ^= mask;
      DEF_SHORT:       while (frame_q.size() > span) void'(frame_q.pop_back());
      DEF_LONG:        while (frame_q.size() < span) frame_q.push_back(8'($urandom));
      DEF_NOISE: begin
        frame_q.delete();
        repeat (span) frame_q.push_back(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic send_frame(input logic [31:0] final_now);
    bit          quiet;
    bit          eob;
    logic [31:0] now;
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < frame_q.size(); i++) begin
      if (idle_enable && !quiet && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      eob = (i == frame_q.size() - 1);
      now = eob ? final_now : $urandom;
      in_valid         <= 1'b1;
      in_data_byte     <= frame_q[i];
      in_end_of_buffer <= eob;
      in_now_ms        <= now;
      do @(posedge clk); while (!in_ready);
      sb.note_beat(frame_q[i], eob, now);
      beats_sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic run_random(input int n_beats);
    int            start;
    int            pick;
    int            span;
    frame_defect_t d;
    logic [31:0]   now;
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      pick = $urandom_range(0, 99);
      span = 0;
      if (pick < 55)      d = DEF_NONE;
      else if (pick < 62) d = DEF_SHORT;
      else if (pick < 67) d = DEF_LONG;
      else if (pick < 72) d = DEF_SYNC_FIRST;
      else if (pick < 76) d = DEF_SYNC_SECOND;
      else if (pick < 82) d = DEF_CHECKSUM;
      else if (pick < 85) d = DEF_VERSION;
      else if (pick < 88) d = DEF_TYPE;
      else if (pick < 91) d = DEF_LEN_LO;
      else if (pick < 94) d = DEF_LEN_HI;
      else                d = DEF_NOISE;
      case (d)
        DEF_SHORT: span = $urandom_range(1, 44);
        DEF_LONG:  span = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 90)
                                                      : $urandom_range(46, 63);
        DEF_NOISE: span = $urandom_range(1, 70);
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0:       now = 32'h0;
        1:       now = 32'hFFFF_FFFF;
        default: now = $urandom;
      endcase
      build_frame(d, -1, span);
      send_frame(now);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_frame(DEF_NONE, -1, 0);
    send_frame($urandom);
    drain();

    cfg_write_all(8'hA5, 8'h5A, 8'h01, 8'h02);
    build_frame(DEF_NONE, 'h8000, 0);
    send_frame(32'hFFFF_FFFF);
    build_frame(DEF_SHORT, -1, 1);
    send_frame($urandom);
    build_frame(DEF_SHORT, -1, 44);
    send_frame($urandom);
    build_frame(DEF_LONG, -1, 70);
    send_frame($urandom);
    drain();

    cfg_write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random(40);
    drain();

    idle_enable = 1'b0;
    cfg_write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random(30);
    drain();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
